/* design/complex_number_alu_top_assert.svh */
// Assertion macros for the complex ALU.
`ifndef COMPLEX_NUMBER_ALU_TOP_ASSERT_SVH
`define COMPLEX_NUMBER_ALU_TOP_ASSERT_SVH
`define CNA_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define CNA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* design/cna_pkg.sv */
// Package: types, constants and helper functions for the complex ALU.
`default_nettype none
package cna_pkg;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS = 31;
  localparam int ISQRT_STEPS = 32;
  localparam int DIV_STEPS = 72;
  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;

  typedef enum logic [3:0] {
    M_RE, M_IM, M_ABS, M_ARG, M_I, M_CONJ, M_ADD, M_SUB,
    M_MUL, M_DIV, M_NEG, M_EQ, M_NE, M_TO_INT, M_FROM_INT, M_FROM_IMAG
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_SAT = 2'd1, ST_DIV0 = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0] mode;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic truth;
    logic [1:0] status;
  } out_t;

  // Per-item working set that travels down the cell chain.
  typedef struct packed {
    logic vld;
    logic [3:0] mode;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
    // isqrt
    logic [63:0] sq_v;
    logic [63:0] sq_res;
    // cordic
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [37:0] cz;
    // divide: restoring, shared by both parts
    logic [63:0] dv_d;
    logic [135:0] dv_re_r;
    logic [71:0] dv_re_q;
    logic dv_re_n;
    logic [135:0] dv_im_r;
    logic [71:0] dv_im_q;
    logic dv_im_n;
  } work_t;

  function automatic logic [31:0] atan_q30(input int i);
    case (i)
      0: atan_q30 = 32'd843314857;
      1: atan_q30 = 32'd497837829;
      2: atan_q30 = 32'd263043837;
      3: atan_q30 = 32'd133525159;
      4: atan_q30 = 32'd67021687;
      5: atan_q30 = 32'd33543516;
      6: atan_q30 = 32'd16775851;
      7: atan_q30 = 32'd8388437;
      8: atan_q30 = 32'd4194283;
      9: atan_q30 = 32'd2097149;
      default: atan_q30 = (i < 31) ? (32'd1 << (30 - i)) : 32'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

/* design/cna_cell.sv */
// One cell of the chain: one isqrt step (IDX < 32), one CORDIC step (IDX < 31), one divide step.
`default_nettype none
module cna_cell #(
  parameter int IDX = 0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire cna_pkg::work_t w_in,
  output cna_pkg::work_t w_out
);
  import cna_pkg::*;

  work_t w_r, w_nxt;

  always_comb begin
    logic [63:0] bit_v;
    logic signed [35:0] xs, ys;
    logic [135:0] dsh;
    bit_v = '0;
    xs = '0;
    ys = '0;
    dsh = '0;
    w_nxt = w_in;
    if (IDX < ISQRT_STEPS) begin
      bit_v = 64'd1 << (62 - 2 * IDX);
      if (w_in.sq_v >= w_in.sq_res + bit_v) begin
        w_nxt.sq_v = w_in.sq_v - (w_in.sq_res + bit_v);
        w_nxt.sq_res = (w_in.sq_res >> 1) + bit_v;
      end else begin
        w_nxt.sq_res = w_in.sq_res >> 1;
      end
    end
    if (IDX < CORDIC_STEPS) begin
      xs = w_in.cx >>> IDX;
      ys = w_in.cy >>> IDX;
      if (w_in.cy > 0) begin
        w_nxt.cx = w_in.cx + ys;
        w_nxt.cy = w_in.cy - xs;
        w_nxt.cz = w_in.cz + 38'(atan_q30(IDX));
      end else if (w_in.cy < 0) begin
        w_nxt.cx = w_in.cx - ys;
        w_nxt.cy = w_in.cy + xs;
        w_nxt.cz = w_in.cz - 38'(atan_q30(IDX));
      end
    end
    if (IDX < DIV_STEPS) begin
      dsh = {w_in.dv_d, 72'd0} >> (IDX + 1);
      w_nxt.dv_re_q = {w_in.dv_re_q[70:0], 1'b0};
      w_nxt.dv_im_q = {w_in.dv_im_q[70:0], 1'b0};
      if (w_in.dv_re_r >= dsh) begin
        w_nxt.dv_re_r = w_in.dv_re_r - dsh;
        w_nxt.dv_re_q[0] = 1'b1;
      end
      if (w_in.dv_im_r >= dsh) begin
        w_nxt.dv_im_r = w_in.dv_im_r - dsh;
        w_nxt.dv_im_q[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.vld <= 1'b0;
    end else if (en) begin
      w_r <= w_nxt;
    end
  end

  assign w_out = w_r;
endmodule
`default_nettype wire

/* design/complex_number_alu_top.sv */
// Top level: operand prep, chain of iterative cells, and result stages.
// Stages: prep, 72 cells, 2 finish.
// Throughput: one beat per cycle while the output is not stalled; the cell chain holds one item per cell.
// The chain advances whenever the output register is free or being taken.
// Reset clears all valid flags; payload registers keep their contents.
`default_nettype none
`include "complex_number_alu_top_assert.svh"
module complex_number_alu_top #(
  parameter int DATA_WIDTH = cna_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS = cna_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire cna_pkg::in_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output cna_pkg::out_t out_data
);
  import cna_pkg::*;

  localparam int DW = (DATA_WIDTH < 8) ? 8 : ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);
  localparam int FB = (FRAC_BITS < 0) ? 0 : ((FRAC_BITS > 30) ? 30 : FRAC_BITS);
  localparam int NC = DIV_STEPS;
  localparam logic signed [65:0] MAXV = (66'sd1 <<< (DW - 1)) - 66'sd1;
  localparam logic signed [65:0] MINV = -(66'sd1 <<< (DW - 1));

  logic en;
  work_t chain [0:NC];
  work_t prep_r, prep_nxt;
  out_t out_r, out_nxt;
  logic out_vld_r;
  logic fin_vld_r;
  logic [3:0] fin_mode_r;
  logic signed [65:0] fin_re_r, fin_im_r;
  logic fin_s_r, fin_d0_r;
  logic signed [31:0] fin_ar_r, fin_ai_r, fin_br_r, fin_bi_r;

  assign en = !out_vld_r || out_ready;
  assign in_ready = en;

  function automatic logic signed [31:0] sx(input logic [31:0] v);
    logic [31:0] m;
    m = 32'(v << (32 - DW));
    sx = $signed(m) >>> (32 - DW);
  endfunction

  // Prep: sign extension, products (<=32x32 per product), seeds.
  always_comb begin
    logic signed [31:0] ar, ai, br, bi;
    logic signed [65:0] p1, p2;
    logic [65:0] m1;
    logic [63:0] dd;
    ar = sx(in_data.a_re);
    ai = sx(in_data.a_im);
    br = sx(in_data.b_re);
    bi = sx(in_data.b_im);
    prep_nxt = '0;
    prep_nxt.vld = in_valid;
    prep_nxt.mode = in_data.mode;
    prep_nxt.ar = ar;
    prep_nxt.ai = ai;
    prep_nxt.br = br;
    prep_nxt.bi = bi;
    prep_nxt.sq_v = 64'(ar * ar) + 64'(ai * ai);
    if (ar < 0) begin
      prep_nxt.cx = -36'(ar);
      prep_nxt.cy = -36'(ai);
      prep_nxt.cz = (ai >= 0) ? 38'(PI_Q30) : -38'(PI_Q30);
    end else begin
      prep_nxt.cx = 36'(ar);
      prep_nxt.cy = 36'(ai);
    end
    dd = 64'(br * br) + 64'(bi * bi);
    // mul carries its products in the remainder lanes; a zero divisor leaves them intact
    prep_nxt.dv_d = (in_data.mode == M_MUL) ? 64'd0 : dd;
    if (in_data.mode == M_MUL) begin
      p1 = 66'(ar * br) - 66'(ai * bi);
      p2 = 66'(ar * bi) + 66'(ai * br);
    end else begin
      p1 = 66'(ar * br) + 66'(ai * bi);
      p2 = 66'(ai * br) - 66'(ar * bi);
    end
    prep_nxt.dv_re_n = p1 < 0;
    m1 = p1 < 0 ? 66'(-p1) : 66'(p1);
    prep_nxt.dv_re_r = 136'(m1) << FB;
    prep_nxt.dv_im_n = p2 < 0;
    m1 = p2 < 0 ? 66'(-p2) : 66'(p2);
    prep_nxt.dv_im_r = 136'(m1) << FB;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.vld <= 1'b0;
    end else if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign chain[0] = prep_r;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    cna_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .w_in(chain[g]), .w_out(chain[g + 1])
    );
  end

  // Finish stage 1: pick unsaturated result per mode.
  always_ff @(posedge clk) begin
    logic signed [65:0] re, im, z;
    logic [71:0] q;
    logic s, d0;
    work_t w;
    w = chain[NC];
    re = '0;
    im = '0;
    s = 1'b0;
    d0 = 1'b0;
    case (mode_t'(w.mode))
      M_RE: re = 66'(w.ar);
      M_IM: re = 66'(w.ai);
      M_ABS: re = 66'(w.sq_res);
      M_ARG: begin
        z = 66'(w.cz);
        re = (FB == 30) ? z : ((z + (66'sd1 <<< (29 - FB))) >>> (30 - FB));
      end
      M_I: im = 66'sd1 <<< FB;
      M_CONJ: begin
        re = 66'(w.ar);
        im = -66'(w.ai);
      end
      M_ADD: begin
        re = 66'(w.ar) + 66'(w.br);
        im = 66'(w.ai) + 66'(w.bi);
      end
      M_SUB: begin
        re = 66'(w.ar) - 66'(w.br);
        im = 66'(w.ai) - 66'(w.bi);
      end
      M_MUL: begin
        q = 72'((w.dv_re_r >> FB) + (FB > 0 ? (136'd1 << (FB - 1)) : 136'd0)) >> FB;
        re = (q > 72'h3_FFFF_FFFF) ? 66'sh3_FFFF_FFFF : 66'(q);
        if (w.dv_re_n) re = -re;
        q = 72'((w.dv_im_r >> FB) + (FB > 0 ? (136'd1 << (FB - 1)) : 136'd0)) >> FB;
        im = (q > 72'h3_FFFF_FFFF) ? 66'sh3_FFFF_FFFF : 66'(q);
        if (w.dv_im_n) im = -im;
      end
      M_DIV: begin
        if (w.dv_d == 64'd0) begin
          d0 = 1'b1;
        end else begin
          q = w.dv_re_q;
          re = (q > 72'h3_FFFF_FFFF) ? 66'sh3_FFFF_FFFF : 66'(q);
          if (w.dv_re_n) re = -re;
          q = w.dv_im_q;
          im = (q > 72'h3_FFFF_FFFF) ? 66'sh3_FFFF_FFFF : 66'(q);
          if (w.dv_im_n) im = -im;
        end
      end
      M_NEG: begin
        re = -66'(w.ar);
        im = -66'(w.ai);
      end
      M_TO_INT: re = (w.ar >= 0) ? (66'(w.ar) >>> FB) : -((-66'(w.ar)) >>> FB);
      M_FROM_INT: re = 66'(w.ar) <<< FB;
      M_FROM_IMAG: im = 66'(w.ar);
      default: ;
    endcase
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= w.vld;
      fin_mode_r <= w.mode;
      fin_re_r <= re;
      fin_im_r <= im;
      fin_s_r <= s;
      fin_d0_r <= d0;
      fin_ar_r <= w.ar;
      fin_ai_r <= w.ai;
      fin_br_r <= w.br;
      fin_bi_r <= w.bi;
    end
  end

  // Finish stage 2: saturate, compare, status.
  always_comb begin
    logic s;
    s = fin_s_r;
    out_nxt = '0;
    if (fin_re_r > MAXV) begin
      out_nxt.res_re = 32'(MAXV);
      s = 1'b1;
    end else if (fin_re_r < MINV) begin
      out_nxt.res_re = 32'(MINV);
      s = 1'b1;
    end else begin
      out_nxt.res_re = 32'(fin_re_r);
    end
    if (fin_im_r > MAXV) begin
      out_nxt.res_im = 32'(MAXV);
      s = 1'b1;
    end else if (fin_im_r < MINV) begin
      out_nxt.res_im = 32'(MINV);
      s = 1'b1;
    end else begin
      out_nxt.res_im = 32'(fin_im_r);
    end
    if (fin_mode_r == M_EQ) begin
      out_nxt.truth = (fin_ar_r == fin_br_r) && (fin_ai_r == fin_bi_r);
    end else if (fin_mode_r == M_NE) begin
      out_nxt.truth = (fin_ar_r != fin_br_r) || (fin_ai_r != fin_bi_r);
    end
    out_nxt.status = fin_d0_r ? ST_DIV0 : (s ? ST_SAT : ST_OK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= fin_vld_r;
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data = out_r;

  `CNA_ASSERT_NEXT(a_hold, out_vld_r && !out_ready, out_vld_r && $stable(out_r))
  `CNA_ASSERT_IMPL(a_rdy, !out_vld_r, in_ready)
  `CNA_ASSERT_IMPL(a_stat, out_vld_r, out_r.status != 2'd3)
endmodule
`default_nettype wire
